// ===== sv/polygon_plane_clipper_assert.svh =====
// Assertion macros shared by the polygon plane clipper RTL.
// Expects clk and rst_n in the scope of the module that uses them.
`ifndef POLYGON_PLANE_CLIPPER_ASSERT_SVH
`define POLYGON_PLANE_CLIPPER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define PCL_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define PCL_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/pcl_pkg.sv =====
// Shared widths, register indexes, state types and status struct of the
// polygon plane clipper. No dependencies.
package pcl_pkg;

  localparam int COORD_BITS = 32;
  localparam int NRM_BITS   = 32;
  localparam int OFS_BITS   = 64;
  localparam int PT_BITS    = (COORD_BITS > 32) ? COORD_BITS : 32;
  localparam int PRD_BITS   = NRM_BITS + PT_BITS;
  // side value: offset plus three products, with headroom
  localparam int FW         = ((PRD_BITS + 2 > OFS_BITS) ? PRD_BITS + 2 : OFS_BITS) + 1;
  localparam int MAGW       = FW;
  localparam int DW         = COORD_BITS + 1;
  localparam int PW         = MAGW + DW;
  localparam int DCNT_W     = $clog2(DW);
  localparam int DATA_W     = ((3 * COORD_BITS + 7) / 8) * 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_REF_X    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_REF_Y    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_REF_Z    = 3'd6;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SIDE_REF,
    ST_SIDE_S,
    ST_SIDE_P,
    ST_CLASSIFY,
    ST_CROSS_GO,
    ST_CROSS_WAIT,
    ST_EMIT_C,
    ST_EMIT_P,
    ST_NEXT,
    ST_EMIT_END
  } clip_state_t;

  typedef enum logic [1:0] {
    MD_IDLE,
    MD_MUL,
    MD_DIV,
    MD_DONE
  } md_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } md_stat_t;

endpackage

// ===== sv/pcl_muldiv.sv =====
// Iterative unsigned multiply-then-divide unit: q = (a * m) / d, truncated.
// Depends on pcl_pkg. Requires a * m < d * 2^DW.
module pcl_muldiv (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [pcl_pkg::MAGW-1:0]  a_in,
  input  logic [pcl_pkg::DW-1:0]    m_in,
  input  logic [pcl_pkg::MAGW-1:0]  d_in,
  output logic [pcl_pkg::DW-1:0]    q_out,
  output pcl_pkg::md_stat_t         stat
);

  pcl_pkg::md_state_t              state_r, state_nxt;
  logic [pcl_pkg::MAGW-1:0]        a_r, d_r;
  logic [pcl_pkg::DW-1:0]          m_r;
  logic [pcl_pkg::PW-1:0]          acc_r, mul_nxt, div_nxt;
  logic [pcl_pkg::DCNT_W-1:0]      cnt_r;
  logic [pcl_pkg::MAGW:0]          trial, trial_sub;
  logic                            ge, last;

  assign last = (cnt_r == pcl_pkg::DCNT_W'(pcl_pkg::DW - 1));

  // shift-add, one multiplier bit per cycle from the top
  assign mul_nxt = {acc_r[pcl_pkg::PW-2:0], 1'b0}
                 + (m_r[pcl_pkg::DW-1] ? pcl_pkg::PW'(a_r) : '0);

  // restoring division, one quotient bit per cycle
  assign trial     = {acc_r[pcl_pkg::PW-1:pcl_pkg::DW], acc_r[pcl_pkg::DW-1]};
  assign trial_sub = trial - {1'b0, d_r};
  assign ge        = (trial >= {1'b0, d_r});
  assign div_nxt   = {(ge ? trial_sub[pcl_pkg::MAGW-1:0] : trial[pcl_pkg::MAGW-1:0]),
                      acc_r[pcl_pkg::DW-2:0], ge};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pcl_pkg::MD_IDLE: if (start) state_nxt = pcl_pkg::MD_MUL;
      pcl_pkg::MD_MUL:  if (last) state_nxt = pcl_pkg::MD_DIV;
      pcl_pkg::MD_DIV:  if (last) state_nxt = pcl_pkg::MD_DONE;
      pcl_pkg::MD_DONE: state_nxt = pcl_pkg::MD_IDLE;
      default:          state_nxt = pcl_pkg::MD_IDLE;
    endcase
  end

  always_comb begin
    stat.busy = (state_r != pcl_pkg::MD_IDLE);
    stat.done = (state_r == pcl_pkg::MD_DONE);
    q_out     = acc_r[pcl_pkg::DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pcl_pkg::MD_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == pcl_pkg::MD_IDLE || last) cnt_r <= '0;
      else                                    cnt_r <= cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      pcl_pkg::MD_IDLE: begin
        if (start) begin
          a_r   <= a_in;
          m_r   <= m_in;
          d_r   <= d_in;
          acc_r <= '0;
        end
      end
      pcl_pkg::MD_MUL: begin
        acc_r <= mul_nxt;
        m_r   <= {m_r[pcl_pkg::DW-2:0], 1'b0};
      end
      pcl_pkg::MD_DIV:  acc_r <= div_nxt;
      pcl_pkg::MD_DONE: acc_r <= acc_r;
      default:          acc_r <= acc_r;
    endcase
  end

endmodule

// ===== sv/polygon_plane_clipper.sv =====
// Polygon plane clipper: Sutherland-Hodgman clipping of a streamed polygon
// against one plane. Send vertices as Q16.16 beats and mark the last with
// in_tlast; each vertex closes the edge from the previous one and the last
// vertex also closes the edge back to the first, so the clipped polygon comes
// out rotated (closing-edge points last), followed by an end-marker beat with
// zero data, out_tuser low and out_tlast high. The kept side is the one holding
// the reference point; points on the plane are kept. One vertex is processed
// at a time: each side value is built one product at a time through one
// shared 32xN multiplier (once for the reference, then for both ends of each
// edge), and every crossing point runs its three coordinates in turn through
// the shared iterative multiply/divide unit. A stalled output holds the
// sequencer until the beat is taken. Write configuration only while the
// block is idle.
// Depends on pcl_pkg, pcl_muldiv and polygon_plane_clipper_assert.svh.
module polygon_plane_clipper (
  input  logic                             clk,
  input  logic                             rst_n,
  // in_tdata: vx, vy, vz (low to high), zero padded
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [pcl_pkg::DATA_W-1:0]       in_tdata,
  input  logic                             in_tlast,   // final_vertex
  // out_tdata: ox, oy, oz (low to high), zero padded
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [pcl_pkg::DATA_W-1:0]       out_tdata,
  output logic                             out_tlast,  // polygon_end
  output logic                             out_tuser,  // is_vertex
  input  logic                             cfg_wr_en,
  input  logic [pcl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pcl_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

`include "polygon_plane_clipper_assert.svh"

  localparam int CB = pcl_pkg::COORD_BITS;

  // configuration
  logic signed [pcl_pkg::NRM_BITS-1:0] nrm_r [3];
  logic signed [pcl_pkg::NRM_BITS-1:0] ref_r [3];
  logic signed [pcl_pkg::OFS_BITS-1:0] ofs_r;

  // polygon and edge state
  pcl_pkg::clip_state_t    state_r, state_nxt;
  logic                    in_polygon_r, e0_r, fin_r, edge1_r;
  logic signed [CB-1:0]    first_r [3];
  logic signed [CB-1:0]    prev_r  [3];
  logic signed [CB-1:0]    s_r     [3];
  logic signed [CB-1:0]    p_r     [3];
  logic signed [CB-1:0]    c_r     [3];
  logic signed [CB-1:0]    vin     [3];

  // side value evaluation
  logic [1:0]                           tk_r;
  logic                                 side_last;
  logic signed [pcl_pkg::NRM_BITS-1:0]  n_sel;
  logic signed [pcl_pkg::PT_BITS-1:0]   pt_sel;
  logic signed [pcl_pkg::PRD_BITS-1:0]  mul_w, prod_r;
  logic signed [pcl_pkg::FW-1:0]        acc_r, f_new, fs_r, fp_r;
  logic                                 rs_neg_r, rs_nz_r;

  // classify and crossing
  logic                         os_w, op_w, os_r;
  logic [pcl_pkg::MAGW-1:0]     a_w, d_w, a_r, d_r;
  logic signed [pcl_pkg::FW:0]  fdiff;
  logic [1:0]                   crd_r;
  logic signed [pcl_pkg::DW-1:0] cdiff;
  logic [pcl_pkg::DW-1:0]       mag_w, q_w, cres;
  logic                         cneg_r;
  pcl_pkg::md_stat_t            md_stat;

  // control strobes
  logic in_acc, load_e1, md_start, out_free, emit_ld;

  // output register
  logic                        out_tvalid_r, out_tlast_r, out_tuser_r;
  logic [pcl_pkg::DATA_W-1:0]  out_tdata_r, emit_data;

  always_comb begin
    for (int i = 0; i < 3; i++) vin[i] = in_tdata[i*CB +: CB];
  end

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        nrm_r[i] <= '0;
        ref_r[i] <= '0;
      end
      ofs_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        pcl_pkg::CFG_NORMAL_X: nrm_r[0] <= cfg_wdata[pcl_pkg::NRM_BITS-1:0];
        pcl_pkg::CFG_NORMAL_Y: nrm_r[1] <= cfg_wdata[pcl_pkg::NRM_BITS-1:0];
        pcl_pkg::CFG_NORMAL_Z: nrm_r[2] <= cfg_wdata[pcl_pkg::NRM_BITS-1:0];
        pcl_pkg::CFG_OFFSET:   ofs_r    <= cfg_wdata[pcl_pkg::OFS_BITS-1:0];
        pcl_pkg::CFG_REF_X:    ref_r[0] <= cfg_wdata[pcl_pkg::NRM_BITS-1:0];
        pcl_pkg::CFG_REF_Y:    ref_r[1] <= cfg_wdata[pcl_pkg::NRM_BITS-1:0];
        pcl_pkg::CFG_REF_Z:    ref_r[2] <= cfg_wdata[pcl_pkg::NRM_BITS-1:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // ---------------------------------------------------------- side value
  // f(pt) = offset + n.pt, one product per cycle, each accumulated in the cycle after.
  assign side_last = (tk_r == 2'd3);

  always_comb begin
    n_sel  = '0;
    pt_sel = '0;
    if (tk_r != 2'd3) begin
      n_sel = nrm_r[tk_r];
      unique case (state_r)
        pcl_pkg::ST_SIDE_REF: pt_sel = pcl_pkg::PT_BITS'(ref_r[tk_r]);
        pcl_pkg::ST_SIDE_S:   pt_sel = pcl_pkg::PT_BITS'(s_r[tk_r]);
        default:              pt_sel = pcl_pkg::PT_BITS'(p_r[tk_r]);
      endcase
    end
  end

  assign mul_w = n_sel * pt_sel;
  assign f_new = acc_r + pcl_pkg::FW'(prod_r);

  // --------------------------------------------------------- classify
  always_comb begin
    os_w  = (fs_r != '0) && rs_nz_r && (fs_r[pcl_pkg::FW-1] != rs_neg_r);
    op_w  = (fp_r != '0) && rs_nz_r && (fp_r[pcl_pkg::FW-1] != rs_neg_r);
    a_w   = fs_r[pcl_pkg::FW-1] ? pcl_pkg::MAGW'(-fs_r) : pcl_pkg::MAGW'(fs_r);
    fdiff = (pcl_pkg::FW+1)'(fp_r) - (pcl_pkg::FW+1)'(fs_r);
    d_w   = fdiff[pcl_pkg::FW] ? pcl_pkg::MAGW'(-fdiff) : pcl_pkg::MAGW'(fdiff);
  end

  // --------------------------------------------------------- crossing
  // c = s + sign(p - s) * (|f(s)| * |p - s|) / |f(p) - f(s)|
  assign cdiff = pcl_pkg::DW'(p_r[crd_r]) - pcl_pkg::DW'(s_r[crd_r]);
  assign mag_w = cdiff[pcl_pkg::DW-1] ? pcl_pkg::DW'(-cdiff) : pcl_pkg::DW'(cdiff);
  assign cres  = cneg_r ? (pcl_pkg::DW'(s_r[crd_r]) - q_w)
                        : (pcl_pkg::DW'(s_r[crd_r]) + q_w);

  pcl_muldiv u_muldiv (
    .clk   (clk),
    .rst_n (rst_n),
    .start (md_start),
    .a_in  (a_r),
    .m_in  (mag_w),
    .d_in  (d_r),
    .q_out (q_w),
    .stat  (md_stat)
  );

  // ---------------------------------------------------------- sequencer
  assign out_free = !out_tvalid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pcl_pkg::ST_IDLE:
        if (in_tvalid) state_nxt = pcl_pkg::ST_SIDE_REF;
      pcl_pkg::ST_SIDE_REF:
        if (side_last) begin
          if (e0_r || fin_r) state_nxt = pcl_pkg::ST_SIDE_S;
          else               state_nxt = pcl_pkg::ST_IDLE;
        end
      pcl_pkg::ST_SIDE_S:
        if (side_last) state_nxt = pcl_pkg::ST_SIDE_P;
      pcl_pkg::ST_SIDE_P:
        if (side_last) state_nxt = pcl_pkg::ST_CLASSIFY;
      pcl_pkg::ST_CLASSIFY: begin
        if (!os_w && !op_w)    state_nxt = pcl_pkg::ST_EMIT_P;
        else if (os_w && op_w) state_nxt = pcl_pkg::ST_NEXT;
        else                   state_nxt = pcl_pkg::ST_CROSS_GO;
      end
      pcl_pkg::ST_CROSS_GO:
        state_nxt = pcl_pkg::ST_CROSS_WAIT;
      pcl_pkg::ST_CROSS_WAIT:
        if (md_stat.done) begin
          if (crd_r == 2'd2) state_nxt = pcl_pkg::ST_EMIT_C;
          else               state_nxt = pcl_pkg::ST_CROSS_GO;
        end
      pcl_pkg::ST_EMIT_C:
        if (out_free) state_nxt = os_r ? pcl_pkg::ST_EMIT_P : pcl_pkg::ST_NEXT;
      pcl_pkg::ST_EMIT_P:
        if (out_free) state_nxt = pcl_pkg::ST_NEXT;
      pcl_pkg::ST_NEXT: begin
        if (fin_r && !edge1_r) state_nxt = pcl_pkg::ST_SIDE_S;
        else if (fin_r)        state_nxt = pcl_pkg::ST_EMIT_END;
        else                   state_nxt = pcl_pkg::ST_IDLE;
      end
      pcl_pkg::ST_EMIT_END:
        if (out_free) state_nxt = pcl_pkg::ST_IDLE;
      default: state_nxt = pcl_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready = (state_r == pcl_pkg::ST_IDLE);
    in_acc    = in_tready && in_tvalid;
    // closing edge: last vertex back to the first
    load_e1   = ((state_r == pcl_pkg::ST_SIDE_REF) && side_last && !e0_r && fin_r) ||
                ((state_r == pcl_pkg::ST_NEXT) && fin_r && !edge1_r);
    md_start  = (state_r == pcl_pkg::ST_CROSS_GO);
    emit_ld   = out_free && ((state_r == pcl_pkg::ST_EMIT_C) ||
                             (state_r == pcl_pkg::ST_EMIT_P) ||
                             (state_r == pcl_pkg::ST_EMIT_END));
    emit_data = '0;
    unique case (state_r)
      pcl_pkg::ST_EMIT_C:
        for (int i = 0; i < 3; i++) emit_data[i*CB +: CB] = c_r[i];
      pcl_pkg::ST_EMIT_P:
        for (int i = 0; i < 3; i++) emit_data[i*CB +: CB] = p_r[i];
      default: emit_data = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= pcl_pkg::ST_IDLE;
      in_polygon_r <= 1'b0;
      tk_r         <= '0;
      crd_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_acc) in_polygon_r <= !in_tlast;
      if ((state_r == pcl_pkg::ST_SIDE_REF) || (state_r == pcl_pkg::ST_SIDE_S) ||
          (state_r == pcl_pkg::ST_SIDE_P))
        tk_r <= tk_r + 1'b1;
      if (state_r == pcl_pkg::ST_CLASSIFY) crd_r <= '0;
      else if ((state_r == pcl_pkg::ST_CROSS_WAIT) && md_stat.done) crd_r <= crd_r + 1'b1;
      if (emit_ld)         out_tvalid_r <= 1'b1;
      else if (out_tready) out_tvalid_r <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      for (int i = 0; i < 3; i++) begin
        if (!in_polygon_r) first_r[i] <= vin[i];
        prev_r[i] <= vin[i];
        s_r[i]    <= prev_r[i];
        p_r[i]    <= vin[i];
      end
      e0_r    <= in_polygon_r;
      fin_r   <= in_tlast;
      edge1_r <= 1'b0;
    end
    if (load_e1) begin
      for (int i = 0; i < 3; i++) begin
        s_r[i] <= prev_r[i];
        p_r[i] <= first_r[i];
      end
      edge1_r <= 1'b1;
    end

    // hold the accumulator; advance one term per cycle
    if ((state_r == pcl_pkg::ST_SIDE_REF) || (state_r == pcl_pkg::ST_SIDE_S) ||
        (state_r == pcl_pkg::ST_SIDE_P)) begin
      prod_r <= mul_w;
      if (tk_r == 2'd0) acc_r <= pcl_pkg::FW'(ofs_r);
      else              acc_r <= f_new;
      if (side_last) begin
        unique case (state_r)
          pcl_pkg::ST_SIDE_REF: begin
            rs_neg_r <= f_new[pcl_pkg::FW-1];
            rs_nz_r  <= (f_new != '0);
          end
          pcl_pkg::ST_SIDE_S: fs_r <= f_new;
          default:            fp_r <= f_new;
        endcase
      end
    end

    if (state_r == pcl_pkg::ST_CLASSIFY) begin
      os_r <= os_w;
      a_r  <= a_w;
      d_r  <= d_w;
    end
    if (md_start) cneg_r <= cdiff[pcl_pkg::DW-1];
    if ((state_r == pcl_pkg::ST_CROSS_WAIT) && md_stat.done)
      c_r[crd_r] <= cres[CB-1:0];

    if (emit_ld) begin
      out_tdata_r <= emit_data;
      out_tuser_r <= (state_r != pcl_pkg::ST_EMIT_END);
      out_tlast_r <= (state_r == pcl_pkg::ST_EMIT_END);
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;
  assign out_tuser  = out_tuser_r;

  // ---------------------------------------------------------- checks
  `PCL_ASSERT_NXT(a_open_polygon, in_tvalid && in_tready && !in_tlast, in_polygon_r,
                  "vertex without final flag did not leave a polygon open")
  `PCL_ASSERT_NXT(a_close_polygon, in_tvalid && in_tready && in_tlast, !in_polygon_r,
                  "final vertex did not close the polygon")
  `PCL_ASSERT_IMP(a_end_marker, out_tvalid_r && !out_tuser_r,
                  out_tlast_r && (out_tdata_r == '0), "end marker beat malformed")
  `PCL_ASSERT_IMP(a_md_done, md_stat.done, state_r == pcl_pkg::ST_CROSS_WAIT,
                  "divider finished outside crossing wait")

endmodule
